// File: rtl/core/bcc_pkg.sv
// Package for the button click classifier: action codes, register indexes,
// configuration and tracking state types. No dependencies.

package bcc_pkg;

   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned CfgWidth   = 16;
   localparam int unsigned CsrIdxWidth = 2;

   typedef enum logic [2:0] {
      ACT_NONE   = 3'd0,
      ACT_SINGLE = 3'd1,
      ACT_DOUBLE = 3'd2,
      ACT_LONG   = 3'd3,
      ACT_HELD   = 3'd4
   } action_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_DEBOUNCE = 2'd0,
      CSR_DOUBLE   = 2'd1,
      CSR_LONG     = 2'd2
   } csr_index_type;

   localparam logic [CfgWidth-1:0] DebounceReset = 16'd50;
   localparam logic [CfgWidth-1:0] DoubleReset   = 16'd300;
   localparam logic [CfgWidth-1:0] LongReset     = 16'd1000;

   localparam logic [1:0] CountMax = 2'd3;

   typedef struct packed {
      logic [CfgWidth-1:0] debounce_ms;
      logic [CfgWidth-1:0] double_click_ms;
      logic [CfgWidth-1:0] long_click_ms;
   } cfg_type;

   typedef struct packed {
      logic                 is_pressed;
      logic [TimeWidth-1:0] press_start_time;
      logic [TimeWidth-1:0] last_press_time;
      logic [1:0]           click_count;
      logic                 long_reported;
   } state_type;

endpackage

// File: rtl/core/bcc_req_if.sv
// Poll channel: valid/ready handshake carrying a timestamp and button level.
// Depends on bcc_pkg.

interface bcc_req_if import bcc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [TimeWidth-1:0] now_ms;
   logic                 pressed_level;

   modport source (output valid, output now_ms, output pressed_level, input ready);
   modport sink   (input valid, input now_ms, input pressed_level, output ready);
endinterface

// File: rtl/core/bcc_rsp_if.sv
// Result channel: valid/ready handshake carrying the classified action.
// Depends on bcc_pkg.

interface bcc_rsp_if import bcc_pkg::*; ();
   logic       valid;
   logic       ready;
   action_type action;

   modport source (output valid, output action, input ready);
   modport sink   (input valid, input action, output ready);
endinterface

// File: rtl/core/bcc_csr.sv
// Configuration registers of the click classifier, written through a plain
// write port. Depends on bcc_pkg.

module bcc_csr import bcc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0]    csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEBOUNCE: cfg_in.debounce_ms     = csr_wdata;
            CSR_DOUBLE:   cfg_in.double_click_ms = csr_wdata;
            CSR_LONG:     cfg_in.long_click_ms   = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms     <= DebounceReset;
         cfg_ff.double_click_ms <= DoubleReset;
         cfg_ff.long_click_ms   <= LongReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/bcc_step.sv
// Next-state and action logic for one poll: edge tracking then classification.
// Purely combinational. Depends on bcc_pkg.

module bcc_step import bcc_pkg::*; (
   input  cfg_type              cfg,
   input  state_type            cur,
   input  logic [TimeWidth-1:0] now_ms,
   input  logic                 pressed_level,
   output state_type            nxt,
   output action_type           action
);

   logic [TimeWidth-1:0] since;
   logic [TimeWidth-1:0] held_for;
   logic [TimeWidth-1:0] gap;
   logic                 past_debounce;
   state_type            trk;

   always_comb begin
      since         = now_ms - cur.last_press_time;
      past_debounce = since > {16'd0, cfg.debounce_ms};

      // Edge tracking.
      trk = cur;
      if (pressed_level && !cur.is_pressed && past_debounce) begin
         trk.is_pressed       = 1'b1;
         trk.press_start_time = now_ms;
         trk.last_press_time  = now_ms;
         if (since < {16'd0, cfg.double_click_ms}) begin
            if (cur.click_count != CountMax) begin
               trk.click_count = cur.click_count + 2'd1;
            end
         end else begin
            trk.click_count = 2'd1;
         end
      end else if (!pressed_level && cur.is_pressed && past_debounce) begin
         trk.is_pressed = 1'b0;
      end

      held_for = now_ms - trk.press_start_time;
      gap      = now_ms - trk.last_press_time;

      // Classification on the tracked state.
      nxt    = trk;
      action = ACT_NONE;
      priority if (trk.is_pressed) begin
         if (held_for > {16'd0, cfg.long_click_ms}) begin
            if (!trk.long_reported) begin
               nxt.long_reported = 1'b1;
               action            = ACT_LONG;
            end else begin
               action = ACT_HELD;
            end
         end
      end else if (trk.long_reported) begin
         nxt.long_reported = 1'b0;
         nxt.click_count   = 2'd0;
      end else if (trk.click_count == 2'd1 && gap > {16'd0, cfg.double_click_ms}) begin
         nxt.click_count = 2'd0;
         action          = ACT_SINGLE;
      end else if (trk.click_count == 2'd2) begin
         nxt.click_count = 2'd0;
         action          = ACT_DOUBLE;
      end else begin
         // Released with nothing to report: the state stays as tracked.
      end
   end

endmodule

// File: rtl/core/button_click_classifier_core.sv
// Button click classifier: classifies each timestamped poll as no action,
// single, double or long click, or held, via input and result registers;
// one item per cycle if results are taken. Reset is synchronous, active high.
// Depends on bcc_pkg, bcc_req_if, bcc_rsp_if, bcc_csr and bcc_step.

module button_click_classifier_core import bcc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   bcc_req_if.sink                req_ch,
   bcc_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0]    csr_wdata
);

   // An accepted item is first captured in the input register. Once the result
   // slot is free the step logic classifies it against the tracking state, which is
   // updated in that same edge as the action is written to the result
   // register. The following item therefore always sees the state left by
   // the one before it, even when items arrive in every cycle.
   //
   // The result register frees its slot whenever the sink takes the item,
   // and the input register moves on whenever the result slot is free, so
   // the pipeline runs at full rate under no back-pressure and stalls
   // cleanly when the sink holds ready low.

   cfg_type              cfg;
   state_type            state_ff;
   state_type            state_in;
   action_type           step_action;

   logic                 in_valid_ff;
   logic [TimeWidth-1:0] now_ff;
   logic                 level_ff;

   logic                 out_valid_ff;
   action_type           action_ff;

   logic                 out_free;
   logic                 step_fire;
   logic                 req_fire;

   bcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bcc_step u_step (
      .cfg           (cfg),
      .cur           (state_ff),
      .now_ms        (now_ff),
      .pressed_level (level_ff),
      .nxt           (state_in),
      .action        (step_action)
   );

   // Handshake control: the result slot is free when empty or being taken.
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign step_fire    = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         now_ff   <= req_ch.now_ms;
         level_ff <= req_ch.pressed_level;
      end
   end

   // Tracking state only advances when an item is actually classified.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         action_ff <= step_action;
      end
   end

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.action = action_ff;

   // A held report can only follow once the long click has been recorded.
   a_held_state: assert property (@(posedge clock) disable iff (reset)
      (step_fire && step_action == ACT_HELD)
      |=> (state_ff.is_pressed && state_ff.long_reported))
      else $error("held reported without a recorded long click");

   // Reporting a long click records it so it is given only once per press.
   a_long_once: assert property (@(posedge clock) disable iff (reset)
      (step_fire && step_action == ACT_LONG) |=> state_ff.long_reported)
      else $error("long click not recorded after being reported");

   // Single and double click reports clear the click count.
   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      (step_fire && (step_action == ACT_SINGLE || step_action == ACT_DOUBLE))
      |=> (state_ff.click_count == 2'd0))
      else $error("click count not cleared after a click report");

   // A result only appears when an item sat in the input register.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff))
      else $error("result appeared without an item in flight");

endmodule

// File: sim/bcc_click_predict_pkg.sv
// Scoreboard for the button click classifier testbench: predicts the action
// for every accepted poll and checks results in order. Depends on bcc_pkg.

package bcc_click_predict_pkg;
   import bcc_pkg::*;

   class click_scoreboard;
      cfg_type     cfg;
      state_type   st;
      action_type  expected_actions[$];
      int unsigned errors;
      int unsigned results_seen;
      int unsigned action_tally[5];

      function new();
         cfg = '{DebounceReset, DoubleReset, LongReset};
         st  = '0;
      endfunction

      function void apply_register(logic [CsrIdxWidth-1:0] index, logic [CfgWidth-1:0] value);
         case (index)
            CSR_DEBOUNCE: cfg.debounce_ms     = value;
            CSR_DOUBLE:   cfg.double_click_ms = value;
            CSR_LONG:     cfg.long_click_ms   = value;
            default: ;
         endcase
      endfunction

      // Edge tracking first, then classification, exactly one action per poll.
      function void note_poll(logic [TimeWidth-1:0] now, logic level);
         logic [TimeWidth-1:0] since_press;
         logic [TimeWidth-1:0] held_for;
         action_type           act;
         since_press = now - st.last_press_time;
         if (level) begin
            if (!st.is_pressed && since_press > {16'd0, cfg.debounce_ms}) begin
               st.is_pressed       = 1'b1;
               st.press_start_time = now;
               if (since_press < {16'd0, cfg.double_click_ms}) begin
                  if (st.click_count != CountMax)
                     st.click_count = st.click_count + 2'd1;
               end else begin
                  st.click_count = 2'd1;
               end
               st.last_press_time = now;
            end
         end else if (st.is_pressed && since_press > {16'd0, cfg.debounce_ms}) begin
            st.is_pressed = 1'b0;
         end

         act         = ACT_NONE;
         held_for    = now - st.press_start_time;
         since_press = now - st.last_press_time;
         if (st.is_pressed) begin
            if (held_for > {16'd0, cfg.long_click_ms}) begin
               if (st.long_reported)
                  act = ACT_HELD;
               else
                  act = ACT_LONG;
               st.long_reported = 1'b1;
            end
         end else if (st.long_reported) begin
            st.long_reported = 1'b0;
            st.click_count   = 2'd0;
         end else if (st.click_count == 2'd1 && since_press > {16'd0, cfg.double_click_ms}) begin
            st.click_count = 2'd0;
            act            = ACT_SINGLE;
         end else if (st.click_count == 2'd2) begin
            st.click_count = 2'd0;
            act            = ACT_DOUBLE;
         end
         expected_actions.push_back(act);
      endfunction

      function void check_action(logic [2:0] got);
         action_type want;
         if (expected_actions.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("Unexpected result: action %0d with nothing outstanding", got);
            return;
         end
         want = expected_actions.pop_front();
         results_seen++;
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("Action mismatch on result %0d: expected %s (%0d), got %0d",
                        results_seen, want.name(), want, got);
         end else begin
            action_tally[int'(want)]++;
         end
      endfunction

      function int unsigned pending();
         return expected_actions.size();
      endfunction
   endclass

endpackage

// File: sim/button_click_classifier_core_tb.sv
// Self-checking testbench for button_click_classifier_core: directed polls,
// then random click gestures under several register settings and idling modes.
// Depends on bcc_pkg, bcc_req_if, bcc_rsp_if and bcc_click_predict_pkg.

module button_click_classifier_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bcc_pkg::*;
   import bcc_click_predict_pkg::*;

   // Generous ceiling: the slowest correct run needs well under a tenth of it.
   localparam int unsigned LimitNs     = 2_000_000;
   // Margin waited out after the last result.
   localparam int unsigned DrainCycles = 4;
   // The register index that decodes to nothing; writes to it must be ignored.
   localparam logic [CsrIdxWidth-1:0] CsrSpare = 2'd3;
   localparam int unsigned DirCount    = 22;

   typedef enum int {
      PRESSURE_NONE,
      PRESSURE_HOLDOFF,
      PRESSURE_DRAIN
   } pressure_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [CfgWidth-1:0]    csr_wdata;

   bcc_req_if req_ch();
   bcc_rsp_if rsp_ch();

   button_click_classifier_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   click_scoreboard      sb = new();
   logic [TimeWidth-1:0] wall_ms;
   int unsigned          polls_sent;
   int unsigned          settings_used;
   int unsigned          sender_idle_pct;
   int unsigned          receiver_stall_pct;
   int unsigned          rsp_hold_request;

   // Directed polls, run under the reset register values (50, 300, 1000 ms).
   // In order: a press too soon after time zero is swallowed by the debounce;
   // a real press with a bounce on release, then a single click once the
   // double-click window has passed; two quick presses giving a double click;
   // a hold that becomes a long click, then held, then a quiet release;
   // a timestamp going backwards, which reads as a huge interval; a press
   // just before the counter wraps with releases just after it; and finally
   // the largest timestamp and a mid-range one.
   logic [TimeWidth-1:0] dir_time [DirCount] = '{
      32'd0, 32'd100, 32'd120, 32'd200, 32'd450,
      32'd1000, 32'd1100, 32'd1200, 32'd1300,
      32'd3000, 32'd3500, 32'd4001, 32'd4100, 32'd4200,
      32'd100, 32'd50,
      32'hFFFF_FFF0, 32'h0000_0020, 32'h0000_0040, 32'h0000_0200,
      32'hFFFF_FFFF, 32'h7FFF_FFFF
   };
   logic dir_level [DirCount] = '{
      1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
      1'b1, 1'b0, 1'b1, 1'b0,
      1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
      1'b1, 1'b0,
      1'b1, 1'b0, 1'b0, 1'b0,
      1'b1, 1'b0
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs or drops an item.
   initial begin
      #(LimitNs);
      $display("button_click_classifier_core regression: fail");
      $finish;
   end

   // Result side. Handshakes are sampled at the rising edge, before any of
   // this edge's updates land, and ready is then chosen for the next cycle.
   // A hold-off request from the stimulus process is counted down here, one
   // cycle at a time, while the sender keeps offering items.
   initial begin : result_sink
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            sb.check_action(rsp_ch.action);
         if (rsp_hold_request != 0) begin
            hold_left        = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !reset && ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Offers one poll, idling first as the current mode asks, and returns in
   // the time step of the edge that accepted it. Valid is left high so that
   // a following item can go straight out.
   task automatic send_at(logic [TimeWidth-1:0] stamp, logic level);
      wall_ms = stamp;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.now_ms        <= stamp;
      req_ch.pressed_level <= level;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_poll(stamp, level);
      polls_sent++;
   endtask

   task automatic send_poll(logic [TimeWidth-1:0] delta, logic level);
      send_at(wall_ms + delta, level);
   endtask

   // Stops offering items and waits for every outstanding result.
   task automatic drain_outputs();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Writes all three registers and then the unused index with junk.
   task automatic program_settings(logic [CfgWidth-1:0] debounce, logic [CfgWidth-1:0] window,
                                   logic [CfgWidth-1:0] hold);
      logic [CsrIdxWidth-1:0] idx [4];
      logic [CfgWidth-1:0]    val [4];
      idx = '{CSR_DEBOUNCE, CSR_DOUBLE, CSR_LONG, CsrSpare};
      val = '{debounce, window, hold, CfgWidth'($urandom)};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         sb.apply_register(idx[i], val[i]);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Interval close to one of the configured thresholds: just under, on,
   // just over, well inside or well beyond it, or almost nothing at all.
   function automatic logic [TimeWidth-1:0] gap_around(logic [CfgWidth-1:0] mark);
      logic [TimeWidth-1:0] m;
      m = {16'd0, mark};
      case ($urandom_range(5))
         0:       return (m == 0) ? 32'd0 : m - 1;
         1:       return m;
         2:       return m + 1;
         3:       return 32'($urandom_range(m));
         4:       return m + 32'($urandom_range(m + 5));
         default: return 32'($urandom_range(3));
      endcase
   endfunction

   function automatic logic [TimeWidth-1:0] pick_gap();
      case ($urandom_range(2))
         0:       return gap_around(sb.cfg.debounce_ms);
         1:       return gap_around(sb.cfg.double_click_ms);
         default: return gap_around(sb.cfg.long_click_ms);
      endcase
   endfunction

   // One to four presses with random spacing. Extra polls during a press
   // occasionally read released, which models contact bounce; the trailing
   // polls give a pending single click the chance to be reported.
   task automatic run_gesture();
      int unsigned presses;
      int unsigned extra;
      presses = $urandom_range(1, 4);
      repeat (presses) begin
         send_poll(gap_around($urandom_range(1) ? sb.cfg.double_click_ms
                                                : sb.cfg.debounce_ms), 1'b1);
         extra = $urandom_range(3);
         repeat (extra) send_poll(pick_gap(), $urandom_range(4) != 0);
         send_poll(gap_around(sb.cfg.debounce_ms), 1'b0);
      end
      extra = $urandom_range(1, 3);
      repeat (extra) send_poll(pick_gap(), $urandom_range(9) == 0);
   endtask

   task automatic run_phase(logic [CfgWidth-1:0] debounce, logic [CfgWidth-1:0] window,
                            logic [CfgWidth-1:0] hold, int unsigned idle_pct,
                            int unsigned stall_pct, int unsigned item_count,
                            pressure_type pressure);
      int unsigned target;
      int unsigned noise;
      bit          pressed_on;
      program_settings(debounce, window, hold);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      target             = polls_sent + item_count;
      pressed_on         = 1'b0;
      while (polls_sent < target) begin
         // Halfway through, as the mode asks, choke the result side for a long
         // stretch, let the block empty completely, or simply carry on.
         if (!pressed_on && polls_sent >= target - item_count / 2) begin
            pressed_on = 1'b1;
            if (pressure == PRESSURE_HOLDOFF)
               rsp_hold_request = 300;
            else if (pressure == PRESSURE_DRAIN)
               drain_outputs();
         end
         // Now and then jump close to the top of the counter to force a wrap.
         if ($urandom_range(19) == 0)
            wall_ms = 32'hFFFF_FFFF - 32'($urandom_range(3000));
         if ($urandom_range(4) == 0) begin
            noise = $urandom_range(1, 3);
            repeat (noise) send_at($urandom, 1'($urandom_range(1)));
         end else begin
            run_gesture();
         end
      end
      drain_outputs();
   endtask

   initial begin : stimulus
      int unsigned failures;
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.now_ms        <= '0;
      req_ch.pressed_level <= 1'b0;
      rsp_ch.ready         <= 1'b0;
      csr_we               <= 1'b0;
      csr_index            <= CSR_DEBOUNCE;
      csr_wdata            <= '0;
      wall_ms              = '0;
      polls_sent           = 0;
      settings_used        = 0;
      sender_idle_pct      = 0;
      receiver_stall_pct   = 0;
      rsp_hold_request     = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with the reset values still in place.
      for (int i = 0; i < DirCount; i++)
         send_at(dir_time[i], dir_level[i]);
      drain_outputs();

      // Random part: extremes, the reset values written back, random small
      // and full-range settings, each under one of several idling modes.
      run_phase(16'd0, 16'd0, 16'd0, 74, 0, 105, PRESSURE_NONE);
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 74, 105, PRESSURE_NONE);
      run_phase(16'($urandom_range(1, 400)), 16'($urandom_range(1, 400)),
                16'($urandom_range(1, 400)), 27, 27, 105, PRESSURE_DRAIN);
      run_phase(16'($urandom), 16'($urandom), 16'($urandom), 0, 0, 105, PRESSURE_NONE);
      run_phase(DebounceReset, DoubleReset, LongReset, 74, 0, 105, PRESSURE_NONE);
      run_phase(16'($urandom_range(1, 400)), 16'($urandom_range(1, 400)),
                16'($urandom_range(1, 400)), 0, 74, 105, PRESSURE_HOLDOFF);
      run_phase(16'($urandom_range(400)), 16'($urandom), 16'($urandom_range(2000)),
                27, 27, 105, PRESSURE_NONE);
      run_phase(16'd0, 16'hFFFF, 16'd0, 0, 0, 105, PRESSURE_HOLDOFF);

      failures = sb.errors + sb.pending();
      $display("Ran %0d polls over %0d register settings, %0d results checked.",
               polls_sent, settings_used, sb.results_seen);
      $display("Matched actions: none %0d, single %0d, double %0d, long %0d, held %0d.",
               sb.action_tally[0], sb.action_tally[1], sb.action_tally[2],
               sb.action_tally[3], sb.action_tally[4]);
      if (failures == 0)
         $display("button_click_classifier_core regression: pass");
      else
         $display("button_click_classifier_core regression: fail");
      $finish;
   end

endmodule
